@@ hw/rtl/cgpd_pkg.sv @@
// Shared types, constants and helpers for the CTC greedy plate decoder.
`timescale 1ns / 1ps

package cgpd_pkg;

  localparam int DEF_MAX_TIMESTEPS = 64;
  localparam int DEF_SCORE_BITS    = 16;

  localparam int CLS_W   = 6;
  localparam int CNT_W   = 7;
  localparam int SUM_W   = 22;
  localparam int CONF_W  = 16;
  localparam int ASCII_W = 7;
  localparam int OUT_W   = 48;
  localparam int ADDR_W  = 5;
  localparam int DATA_W  = 32;

  localparam logic [CLS_W-1:0] TABLE_SIZE   = 6'd36;
  localparam logic [CNT_W-1:0] MAX_CLASSES  = 7'd64;
  localparam logic [SUM_W-1:0] SUM_CAP      = {SUM_W{1'b1}};

  localparam logic [CNT_W-1:0]  RST_CLASS_COUNT  = 7'd37;
  localparam logic [CLS_W-1:0]  RST_CHARSET_SIZE = 6'd36;
  localparam logic [CNT_W-1:0]  RST_MIN_LENGTH   = 7'd4;
  localparam logic [CNT_W-1:0]  RST_MAX_LENGTH   = 7'd8;
  localparam logic [CONF_W-1:0] RST_MIN_CONF     = 16'd39321;

  typedef enum logic [2:0] {
    REG_CLASS_COUNT    = 3'd0,
    REG_CHARSET_SIZE   = 3'd1,
    REG_MIN_LENGTH     = 3'd2,
    REG_MAX_LENGTH     = 3'd3,
    REG_MIN_CONF       = 3'd4
  } cfg_idx_t;

  typedef struct packed {
    logic [CNT_W-1:0]  class_count;
    logic [CLS_W-1:0]  charset_size;
    logic [CNT_W-1:0]  min_length;
    logic [CNT_W-1:0]  max_length;
    logic [CONF_W-1:0] min_conf;
  } cfg_regs_t;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_VERDICT
  } state_t;

  typedef struct packed {
    logic step;
    logic div_start;
    logic verdict;
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic div_done;
  } dp_status_t;

  function automatic logic [ASCII_W-1:0] class_ascii(input logic [CLS_W-1:0] idx);
    if (idx < 6'd10) begin
      return ASCII_W'(7'd48 + {1'b0, idx});
    end else begin
      return ASCII_W'(7'd55 + {1'b0, idx});
    end
  endfunction

endpackage

@@ hw/rtl/cgpd_cfg.sv @@
// APB-style configuration register bank.
`timescale 1ns / 1ps

module cgpd_cfg
  import cgpd_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready,
  output cfg_regs_t         regs
);

  cfg_regs_t regs_r;
  cfg_idx_t  idx;
  logic      wr;

  assign idx        = cfg_idx_t'(cfg_paddr[4:2]);
  assign cfg_pready = 1'b1;
  assign wr         = cfg_psel && cfg_penable && cfg_pwrite;
  assign regs       = regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.class_count    <= RST_CLASS_COUNT;
      regs_r.charset_size   <= RST_CHARSET_SIZE;
      regs_r.min_length     <= RST_MIN_LENGTH;
      regs_r.max_length     <= RST_MAX_LENGTH;
      regs_r.min_conf       <= RST_MIN_CONF;
    end else if (wr) begin
      case (idx)
        REG_CLASS_COUNT:    regs_r.class_count    <= cfg_pwdata[CNT_W-1:0];
        REG_CHARSET_SIZE:   regs_r.charset_size   <= cfg_pwdata[CLS_W-1:0];
        REG_MIN_LENGTH:     regs_r.min_length     <= cfg_pwdata[CNT_W-1:0];
        REG_MAX_LENGTH:     regs_r.max_length     <= cfg_pwdata[CNT_W-1:0];
        REG_MIN_CONF:       regs_r.min_conf       <= cfg_pwdata[CONF_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_CLASS_COUNT:    cfg_prdata = DATA_W'(regs_r.class_count);
      REG_CHARSET_SIZE:   cfg_prdata = DATA_W'(regs_r.charset_size);
      REG_MIN_LENGTH:     cfg_prdata = DATA_W'(regs_r.min_length);
      REG_MAX_LENGTH:     cfg_prdata = DATA_W'(regs_r.max_length);
      REG_MIN_CONF:       cfg_prdata = DATA_W'(regs_r.min_conf);
      default:            cfg_prdata = '0;
    endcase
  end

endmodule

@@ hw/rtl/cgpd_divider.sv @@
// Restoring shift-subtract divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module cgpd_divider
  import cgpd_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic [SUM_W-1:0] dividend,
  input  logic [CNT_W-1:0] divisor,
  output logic [SUM_W-1:0] quotient,
  output logic             done
);

  localparam int ITER_W = $clog2(SUM_W);
  localparam logic [ITER_W-1:0] LAST_ITER = ITER_W'(SUM_W - 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [ITER_W-1:0] iter_r, iter_nxt;
  logic [CNT_W-1:0]  rem_r, rem_nxt;
  logic [SUM_W-1:0]  quo_r, quo_nxt;
  logic [CNT_W-1:0]  div_r, div_nxt;
  logic [CNT_W:0]    shifted;
  logic [CNT_W+1:0]  diff;

  assign shifted  = {rem_r, quo_r[SUM_W-1]};
  assign diff     = {1'b0, shifted} - {2'b00, div_r};
  assign quotient = quo_r;
  assign done     = done_r;

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    iter_nxt = iter_r;
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    div_nxt  = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      iter_nxt = '0;
      rem_nxt  = '0;
      quo_nxt  = dividend;
      div_nxt  = divisor;
    end else if (busy_r) begin
      if (!diff[CNT_W+1]) begin
        rem_nxt = diff[CNT_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[CNT_W-1:0];
        quo_nxt = {quo_r[SUM_W-2:0], 1'b0};
      end
      iter_nxt = iter_r + 1'b1;
      if (iter_r == LAST_ITER) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      iter_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      iter_r <= iter_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    div_r <= div_nxt;
  end

endmodule

@@ hw/rtl/cgpd_datapath.sv @@
// Datapath: running argmax, frame accumulators, averaging and output register.
`timescale 1ns / 1ps

module cgpd_datapath
  import cgpd_pkg::*;
#(
  parameter int MAX_TIMESTEPS = DEF_MAX_TIMESTEPS,
  parameter int SCORE_BITS    = DEF_SCORE_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  cfg_regs_t             regs,
  input  dp_cmd_t               cmd,
  output dp_status_t            status,
  input  logic [SCORE_BITS-1:0] score,
  input  logic                  frame_end,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [OUT_W-1:0]      out_data,
  output logic                  out_kind,
  output logic                  out_end
);

  localparam int CAP_I = (MAX_TIMESTEPS < 127) ? MAX_TIMESTEPS : 127;
  localparam logic [CNT_W-1:0] COUNT_CAP = CAP_I[CNT_W-1:0];
  localparam int EXT_W = (SCORE_BITS > CONF_W) ? SCORE_BITS : CONF_W;
  localparam int ADD_W = ((SCORE_BITS > SUM_W) ? SCORE_BITS : SUM_W) + 1;

  logic [CLS_W-1:0]      pos_r, pos_nxt;
  logic [SCORE_BITS-1:0] best_r, best_nxt;
  logic [CLS_W-1:0]      bcls_r, bcls_nxt;
  logic [CLS_W-1:0]      prev_r, prev_nxt;
  logic [SUM_W-1:0]      sum_r, sum_nxt;
  logic [CNT_W-1:0]      count_r, count_nxt;
  logic                  ov_r, ov_nxt;
  logic [OUT_W-1:0]      od_r, od_nxt;
  logic                  ok_r, ok_nxt;
  logic                  oe_r, oe_nxt;

  logic [CNT_W-1:0]      n_eff;
  logic [CLS_W-1:0]      limit;
  logic                  take;
  logic [SCORE_BITS-1:0] bs;
  logic [CLS_W-1:0]      bc;
  logic [CNT_W-1:0]      pos_inc;
  logic                  close;
  logic                  emit;
  logic [ADD_W-1:0]      sum_add;
  logic [SUM_W-1:0]      sum_sat;
  logic [CNT_W-1:0]      len_char;
  logic [EXT_W-1:0]      bs_ext;
  logic [SUM_W-1:0]      quotient;
  logic                  div_done;
  logic [CONF_W-1:0]     avg;
  logic                  accept;

  cgpd_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.div_start),
    .dividend (sum_r),
    .divisor  (count_r),
    .quotient (quotient),
    .done     (div_done)
  );

  assign status.out_free = !ov_r || out_ready;
  assign status.div_done = div_done;
  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign out_kind  = ok_r;
  assign out_end   = oe_r;

  always_comb begin
    if (regs.class_count == '0) begin
      n_eff = CNT_W'(1);
    end else if (regs.class_count > MAX_CLASSES) begin
      n_eff = MAX_CLASSES;
    end else begin
      n_eff = regs.class_count;
    end
    limit   = (regs.charset_size < TABLE_SIZE) ? regs.charset_size : TABLE_SIZE;
    take    = (pos_r == '0) || (score > best_r);
    bs      = take ? score : best_r;
    bc      = take ? pos_r : bcls_r;
    pos_inc = {1'b0, pos_r} + 1'b1;
    close   = (pos_inc >= n_eff) || frame_end;
    emit    = close && (bc < limit) && (bc != prev_r);
    sum_add = ADD_W'(sum_r) + ADD_W'(bs);
    sum_sat = (sum_add > ADD_W'(SUM_CAP)) ? SUM_CAP : sum_add[SUM_W-1:0];
    len_char = (count_r < COUNT_CAP) ? count_r + 1'b1 : count_r;
    bs_ext  = EXT_W'(bs);
    if (count_r == '0) begin
      avg = '0;
    end else if (quotient > SUM_W'({CONF_W{1'b1}})) begin
      avg = {CONF_W{1'b1}};
    end else begin
      avg = quotient[CONF_W-1:0];
    end
    accept = (count_r != '0) && (count_r >= regs.min_length) &&
             (count_r <= regs.max_length) && (avg >= regs.min_conf);
  end

  always_comb begin
    pos_nxt   = pos_r;
    best_nxt  = best_r;
    bcls_nxt  = bcls_r;
    prev_nxt  = prev_r;
    sum_nxt   = sum_r;
    count_nxt = count_r;
    ov_nxt    = ov_r && !out_ready;
    od_nxt    = od_r;
    ok_nxt    = ok_r;
    oe_nxt    = oe_r;
    if (cmd.step) begin
      if (close) begin
        pos_nxt  = '0;
        best_nxt = '0;
        bcls_nxt = '0;
        prev_nxt = bc;
      end else begin
        pos_nxt  = pos_inc[CLS_W-1:0];
        best_nxt = bs;
        bcls_nxt = bc;
      end
      if (emit) begin
        if (count_r < COUNT_CAP) begin
          count_nxt = len_char;
          sum_nxt   = sum_sat;
        end
        ov_nxt = 1'b1;
        ok_nxt = 1'b0;
        oe_nxt = 1'b0;
        od_nxt = {2'b00, {CONF_W{1'b0}}, len_char, bs_ext[CONF_W-1:0], class_ascii(bc)};
      end
    end else if (cmd.verdict) begin
      ov_nxt    = 1'b1;
      ok_nxt    = 1'b1;
      oe_nxt    = 1'b1;
      od_nxt    = {1'b0, accept, avg, count_r, {CONF_W{1'b0}}, {ASCII_W{1'b0}}};
      pos_nxt   = '0;
      best_nxt  = '0;
      bcls_nxt  = '0;
      prev_nxt  = regs.charset_size;
      sum_nxt   = '0;
      count_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= '0;
      best_r  <= '0;
      bcls_r  <= '0;
      prev_r  <= RST_CHARSET_SIZE;
      sum_r   <= '0;
      count_r <= '0;
      ov_r    <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      best_r  <= best_nxt;
      bcls_r  <= bcls_nxt;
      prev_r  <= prev_nxt;
      sum_r   <= sum_nxt;
      count_r <= count_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    od_r <= od_nxt;
    ok_r <= ok_nxt;
    oe_r <= oe_nxt;
  end

endmodule

@@ hw/rtl/cgpd_ctrl.sv @@
// Controller state machine: input flow control and frame-end sequencing.
`timescale 1ns / 1ps

module cgpd_ctrl
  import cgpd_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  input  logic       in_tlast,
  output logic       in_tready,
  input  dp_status_t status,
  output dp_cmd_t    cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_RUN;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    in_tready     = 1'b0;
    cmd.step      = 1'b0;
    cmd.div_start = 1'b0;
    cmd.verdict   = 1'b0;
    case (state_r)
      ST_RUN: begin
        in_tready = status.out_free;
        cmd.step  = in_tvalid && status.out_free;
        if (cmd.step && in_tlast) begin
          state_nxt = ST_DIV_GO;
        end
      end
      ST_DIV_GO: begin
        cmd.div_start = 1'b1;
        state_nxt     = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (status.div_done) begin
          state_nxt = ST_VERDICT;
        end
      end
      ST_VERDICT: begin
        if (status.out_free) begin
          cmd.verdict = 1'b1;
          state_nxt   = ST_RUN;
        end
      end
      default: state_nxt = ST_RUN;
    endcase
  end

endmodule

@@ hw/rtl/ctc_greedy_plate_decoder.sv @@
// Top level of the CTC greedy licence-plate decoder.
`timescale 1ns / 1ps

// Class scores arrive one per transfer, timestep-major; the block takes one score per
// cycle while the output register is free. A score that closes a timestep and emits a
// character fills the output register, so the next score waits only if that character
// is not taken at once. The score marked with tlast closes the frame: the average
// confidence then comes from a shift-subtract divider that yields one quotient bit per
// cycle, and both the verdict transfer and the next score wait until the divider is
// done. Verdict transfers carry tuser = 1 and tlast = 1; character transfers carry 0.
// Configuration may be written only while no frame-end sequence is running.

module ctc_greedy_plate_decoder
  import cgpd_pkg::*;
#(
  parameter int MAX_TIMESTEPS = DEF_MAX_TIMESTEPS,
  parameter int SCORE_BITS    = DEF_SCORE_BITS,
  localparam int IN_W = ((SCORE_BITS + 7) / 8) * 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_W-1:0]   in_tdata,   // score, zero padding
  input  logic              in_tlast,
  output logic              out_tvalid,
  input  logic              out_tready,
  // char_ascii[6:0], char_conf[22:7], plate_length[29:23], avg_conf[45:30],
  // accepted[46], zero[47]
  output logic [OUT_W-1:0]  out_tdata,
  output logic              out_tuser,  // is_verdict
  output logic              out_tlast,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [ADDR_W-1:0] cfg_paddr,
  input  logic [DATA_W-1:0] cfg_pwdata,
  output logic [DATA_W-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_regs_t  regs;
  dp_cmd_t    cmd;
  dp_status_t status;

  cgpd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .regs        (regs)
  );

  cgpd_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tlast  (in_tlast),
    .in_tready (in_tready),
    .status    (status),
    .cmd       (cmd)
  );

  cgpd_datapath #(
    .MAX_TIMESTEPS (MAX_TIMESTEPS),
    .SCORE_BITS    (SCORE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .regs      (regs),
    .cmd       (cmd),
    .status    (status),
    .score     (in_tdata[SCORE_BITS-1:0]),
    .frame_end (in_tlast),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata),
    .out_kind  (out_tuser),
    .out_end   (out_tlast)
  );

endmodule
